/* src/ect_pkg.sv */
package ect_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE_RADIUS_SQ   = 3'd0,
    REG_INACTIVE_RADIUS_SQ = 3'd1,
    REG_ACTIVE_MIX         = 3'd2,
    REG_INACTIVE_MIX       = 3'd3,
    REG_TIME_MIX           = 3'd4,
    REG_STAY_LIMIT         = 3'd5,
    REG_BECOME_LIMIT       = 3'd6,
    REG_CLEANUP_PERIOD     = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic {
    KIND_EVENT   = 1'b0,
    KIND_CLEANUP = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_WRITE,
    ST_OUT
  } state_e;

  // one tracker entry as stored in memory
  typedef struct packed {
    logic [15:0] loc_x;
    logic [15:0] loc_y;
    logic [31:0] mean;
    logic [31:0] last_hit;
    logic        active;
  } trk_t;

  typedef struct packed {
    logic op;
    logic [8:0] pixel_x;
    logic [8:0] pixel_y;
  } req_t;

  typedef struct packed {
    logic       report_kind;
    logic [5:0] tracker_id;
    logic       assigned;
    logic       was_active;
    logic       now_active;
    logic [8:0] center_x;
    logic [8:0] center_y;
    logic       last;
  } rsp_t;

  function automatic logic [8:0] round_loc(input logic [15:0] v);
    logic [16:0] r;
    r = {1'b0, v} + 17'd64;
    round_loc = (r[16:7] > 10'd511) ? 9'd511 : r[15:7];
  endfunction

endpackage

/* src/ect_stream_if.sv */
interface ect_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/event_cluster_tracker.sv */
// an event request starts a scan that reads one entry a cycle; a matched entry then
// goes through the read and multiply phases and a write that registers the result,
// while an unmatched event gives its result after the scan; the next request is
// taken only after the result is accepted; a cleanup tick emits TableDepth results,
// one per entry, and a plain tick gives no result; one request is in flight at a time
// reset: a sweep clears the tracker memory first; registers take defaults
module event_cluster_tracker
  import ect_pkg::*;
#(
  parameter int unsigned TableDepth = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  ect_stream_if.sink           req_i,
  ect_stream_if.source         rsp_o
);
  localparam int unsigned AW = $clog2(TableDepth + 1);
  localparam int unsigned IW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam logic [AW-1:0] LastId = AW'(TableDepth - 1);

  // configuration registers
  logic [15:0] act_rad_q, inact_rad_q, act_mix_q, inact_mix_q, time_mix_q, period_q;
  logic [31:0] stay_lim_q, become_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_rad_q    <= 16'd400;
      inact_rad_q  <= 16'd900;
      act_mix_q    <= 16'd62259;
      inact_mix_q  <= 16'd52429;
      time_mix_q   <= 16'd62259;
      stay_lim_q   <= 32'd5120;
      become_lim_q <= 32'd2560;
      period_q     <= 16'd100;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ACTIVE_RADIUS_SQ:   act_rad_q    <= cfg_data_i[15:0];
        REG_INACTIVE_RADIUS_SQ: inact_rad_q  <= cfg_data_i[15:0];
        REG_ACTIVE_MIX:         act_mix_q    <= cfg_data_i[15:0];
        REG_INACTIVE_MIX:       inact_mix_q  <= cfg_data_i[15:0];
        REG_TIME_MIX:           time_mix_q   <= cfg_data_i[15:0];
        REG_STAY_LIMIT:         stay_lim_q   <= cfg_data_i;
        REG_BECOME_LIMIT:       become_lim_q <= cfg_data_i;
        REG_CLEANUP_PERIOD:     period_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // tracker memory
  logic         we;
  logic [AW-1:0] waddr, raddr;
  trk_t         wdata, rdata;

  ect_ram #(.Width($bits(trk_t)), .Depth(TableDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr[IW-1:0]), .wdata_i(wdata),
    .raddr_i(raddr[IW-1:0]), .rdata_o(rdata)
  );

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;        // clear sweep position, done at TableDepth
  logic [AW-1:0] cnt_q, cnt_d;        // scan/read address
  logic [AW-1:0] idx_q, idx_d;        // entry under update
  logic          rd_vld_q, rd_vld_d;  // rdata holds entry rd_idx_q during scan
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  req_t          req_q, req_d;
  logic [31:0]   now_q, now_d, lastc_q, lastc_d;
  logic [32:0]   best_a_q, best_a_d, best_i_q, best_i_d;
  logic [AW-1:0] pick_a_q, pick_a_d, pick_i_q, pick_i_d;
  logic          has_a_q, has_a_d, has_i_q, has_i_d;
  logic          clean_q, clean_d;    // running cleanup pass
  trk_t          ent_q, ent_d;
  logic [8:0]    px_q, px_d, py_q, py_d;
  rsp_t          rsp_q, rsp_d;
  logic          rsp_vld_q, rsp_vld_d;

  // products registered between update stages
  logic [31:0] px_old_q, px_new_q, py_old_q, py_new_q;
  logic [47:0] mt_old_q, mt_new_q;
  logic [1:0]  ph_q, ph_d;

  // distance of the entry read last cycle
  logic signed [16:0] dx, dy;
  logic [32:0]        dsq;
  assign dx   = $signed({1'b0, req_q.pixel_x, 7'd0}) - $signed({1'b0, rdata.loc_x});
  assign dy   = $signed({1'b0, req_q.pixel_y, 7'd0}) - $signed({1'b0, rdata.loc_y});
  assign dsq  = 33'(dx * dx) + 33'(dy * dy);

  logic [31:0] tdiff, dq;
  logic [15:0] lmix;
  assign tdiff = now_q - ent_q.last_hit;
  assign dq    = (tdiff[31:24] != 8'd0) ? 32'hFFFF_FFFF : {tdiff[23:0], 8'd0};
  assign lmix  = ent_q.active ? act_mix_q : inact_mix_q;

  logic [32:0] bx, by;
  logic [48:0] bm;
  assign bx = 33'(px_old_q) + 33'(px_new_q) + 33'd32768;
  assign by = 33'(py_old_q) + 33'(py_new_q) + 33'd32768;
  assign bm = 49'(mt_old_q) + 49'(mt_new_q) + 49'd32768;

  logic [31:0] new_mean;
  logic        new_act;
  assign new_mean = bm[47:16];
  assign new_act  = ent_q.active ? (new_mean < stay_lim_q) : (new_mean < become_lim_q);

  always_ff @(posedge clk_i) begin
    px_old_q <= 32'(ent_q.loc_x) * 32'(lmix);
    px_new_q <= 32'({px_q, 7'd0}) * (32'd65536 - 32'(lmix));
    py_old_q <= 32'(ent_q.loc_y) * 32'(lmix);
    py_new_q <= 32'({py_q, 7'd0}) * (32'd65536 - 32'(lmix));
    mt_old_q <= 48'(ent_q.mean) * 48'(time_mix_q);
    mt_new_q <= 48'(dq) * (48'd65536 - 48'(time_mix_q));
  end

  logic [31:0] since;
  assign since = now_q + 32'd1 - lastc_q;

  always_comb begin
    state_d = state_q; clr_d = clr_q; cnt_d = cnt_q; idx_d = idx_q;
    rd_vld_d = 1'b0; rd_idx_d = cnt_q; req_d = req_q;
    now_d = now_q; lastc_d = lastc_q; best_a_d = best_a_q; best_i_d = best_i_q;
    pick_a_d = pick_a_q; pick_i_d = pick_i_q; has_a_d = has_a_q; has_i_d = has_i_q;
    clean_d = clean_q; ent_d = ent_q; px_d = px_q; py_d = py_q;
    rsp_d = rsp_q; rsp_vld_d = rsp_vld_q; ph_d = ph_q;
    we = 1'b0; waddr = idx_q; wdata = ent_q; raddr = cnt_q;
    req_i.ready = 1'b0;
    if (rsp_vld_q && rsp_o.ready) rsp_vld_d = 1'b0;

    if (clr_q != AW'(TableDepth)) begin
      // clear sweep after reset
      we = 1'b1; waddr = clr_q; wdata = '0;
      clr_d = clr_q + AW'(1);
    end else begin
      case (state_q)
        ST_IDLE: begin
          req_i.ready = !rsp_vld_q;
          if (req_i.valid && !rsp_vld_q) begin
            req_d = req_i.data;
            if (req_i.data.op == OP_EVENT) begin
              best_a_d = {3'd0, act_rad_q, 14'd0};
              best_i_d = {3'd0, inact_rad_q, 14'd0};
              has_a_d = 1'b0; has_i_d = 1'b0;
              clean_d = 1'b0;
              raddr = '0; cnt_d = AW'(1); rd_vld_d = 1'b1; rd_idx_d = '0;
              state_d = ST_SCAN;
            end else begin
              now_d = now_q + 32'd1;
              if (since >= 32'(period_q)) begin
                clean_d = 1'b1; idx_d = '0; raddr = '0;
                lastc_d = now_q + 32'd1;
                ph_d = 2'd0;
                state_d = ST_UPD;
              end
            end
          end
        end
        ST_SCAN: begin
          if (rd_vld_q) begin
            if (rdata.active) begin
              if (dsq <= best_a_q) begin
                best_a_d = dsq; pick_a_d = rd_idx_q; has_a_d = 1'b1;
              end
            end else if (dsq <= best_i_q) begin
              best_i_d = dsq; pick_i_d = rd_idx_q; has_i_d = 1'b1;
            end
          end
          if (cnt_q != AW'(TableDepth)) begin
            raddr = cnt_q; rd_vld_d = 1'b1; rd_idx_d = cnt_q;
            cnt_d = cnt_q + AW'(1);
          end else if (!rd_vld_q) begin
            if (!has_a_q && !has_i_q) begin
              rsp_d = '0; rsp_d.report_kind = KIND_EVENT; rsp_d.last = 1'b1;
              rsp_vld_d = 1'b1;
              state_d = ST_OUT;
            end else begin
              idx_d = has_a_q ? pick_a_q : pick_i_q;
              raddr = has_a_q ? pick_a_q : pick_i_q;
              ph_d = 2'd0;
              state_d = ST_UPD;
            end
          end
        end
        ST_UPD: begin
          // phase 0 waits for read, 1 latches entry, 2 products registered
          raddr = idx_q;
          ph_d = ph_q + 2'd1;
          if (ph_q == 2'd1) begin
            ent_d = rdata;
            px_d = clean_q ? round_loc(rdata.loc_x) : req_q.pixel_x;
            py_d = clean_q ? round_loc(rdata.loc_y) : req_q.pixel_y;
          end
          if (ph_q == 2'd3) state_d = ST_WRITE;
        end
        ST_WRITE: begin
          we = 1'b1; waddr = idx_q;
          wdata.loc_x = bx[31:16];
          wdata.loc_y = by[31:16];
          wdata.mean = new_mean;
          wdata.last_hit = now_q;
          wdata.active = new_act;
          rsp_d.report_kind = clean_q ? KIND_CLEANUP : KIND_EVENT;
          rsp_d.tracker_id = 6'(idx_q);
          rsp_d.assigned = 1'b1;
          rsp_d.was_active = ent_q.active;
          rsp_d.now_active = new_act;
          rsp_d.center_x = clean_q ? px_q : round_loc(bx[31:16]);
          rsp_d.center_y = clean_q ? py_q : round_loc(by[31:16]);
          rsp_d.last = !clean_q || (idx_q == LastId);
          rsp_vld_d = 1'b1;
          state_d = ST_OUT;
        end
        ST_OUT: begin
          if (!rsp_vld_q || rsp_o.ready) begin
            if (clean_q && idx_q != LastId) begin
              idx_d = idx_q + AW'(1); raddr = idx_q + AW'(1);
              ph_d = 2'd0;
              state_d = ST_UPD;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; clr_q <= '0; cnt_q <= '0; idx_q <= '0;
      rd_vld_q <= 1'b0; rd_idx_q <= '0; now_q <= '0; lastc_q <= '0;
      rsp_vld_q <= 1'b0; clean_q <= 1'b0; ph_q <= '0;
      has_a_q <= 1'b0; has_i_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; cnt_q <= cnt_d; idx_q <= idx_d;
      rd_vld_q <= rd_vld_d; rd_idx_q <= rd_idx_d; now_q <= now_d; lastc_q <= lastc_d;
      rsp_vld_q <= rsp_vld_d; clean_q <= clean_d; ph_q <= ph_d;
      has_a_q <= has_a_d; has_i_q <= has_i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; best_a_q <= best_a_d; best_i_q <= best_i_d;
    pick_a_q <= pick_a_d; pick_i_q <= pick_i_d; ent_q <= ent_d;
    px_q <= px_d; py_q <= py_d; rsp_q <= rsp_d;
  end

  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;
endmodule

/* src/ect_ram.sv */
module ect_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* src/ect_checker.sv */
module ect_checker
  import ect_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);
  // result holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("rsp dropped");
  // no request taken while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("request taken under result");
  // unmatched events carry zero fields
  a_unmatched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.assigned |-> out_data.last && out_data.tracker_id == 6'd0
    && out_data.report_kind == KIND_EVENT) else $error("bad unmatched result");
  // event results are always last
  a_evlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.report_kind == KIND_EVENT |-> out_data.last) else $error("event not last");
endmodule

bind event_cluster_tracker ect_checker u_ect_checker (
  .clk_i, .rst_ni,
  .in_valid(req_i.valid), .in_ready(req_i.ready),
  .out_valid(rsp_o.valid), .out_ready(rsp_o.ready), .out_data(rsp_o.data)
);
